// ===== rtl/sts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sphere triangle subdivider.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int COUNT_BITS = 21;
    localparam int RADIUS_BITS = 16;
    localparam int BASE_BITS = 24;

    // configuration register indexes
    localparam logic [0:0] CFG_RADIUS = 1'b0;
    localparam logic [0:0] CFG_BASE   = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic       load;      // capture corners
        logic       mid_start; // start one midpoint
        logic [1:0] mid_sel;   // 0 ab, 1 bc, 2 ca
        logic       div_start; // start one axis division
        logic [1:0] axis;      // 0 x, 1 y, 2 z
    } dp_cmd_t;

    // datapath status
    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic zero_len;
    } dp_stat_t;

endpackage

// ===== rtl/sts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_datapath
// Corner registers, midpoint sums, shared square root and divide units.
// ----------------------------------------------------------------------------
module sts_datapath #(
    parameter int COORD_BITS = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sts_pkg::dp_cmd_t              cmd,
    output sts_pkg::dp_stat_t             stat,
    input  logic [sts_pkg::RADIUS_BITS-1:0] radius,
    input  logic signed [COORD_BITS-1:0]  corner_in [9],
    output logic signed [COORD_BITS-1:0]  corner_out [9],
    output logic signed [COORD_BITS-1:0]  mid_out [9]
);
    localparam int SUM_SHIFT = (COORD_BITS > 18) ? COORD_BITS - 18 : 0;
    localparam int MAG_BITS = COORD_BITS + 1 - SUM_SHIFT;
    localparam int SQ_BITS = 2 * MAG_BITS + 2;
    localparam int RAD_BITS = SQ_BITS + 24;   // radicand width (even)
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int NUM_BITS = MAG_BITS + sts_pkg::RADIUS_BITS + 12 + 1;
    localparam int QBITS = NUM_BITS;
    localparam int SQ_ITER_BITS = $clog2(ROOT_BITS + 1);
    localparam int DIV_ITER_BITS = $clog2(QBITS + 1);

    logic signed [COORD_BITS-1:0] corner_reg [9];
    logic signed [COORD_BITS-1:0] mid_reg [9];
    logic [MAG_BITS-1:0] mag_reg [3];
    logic [2:0] neg_reg;
    logic [1:0] sel_reg;

    // corner capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 9; i++)
                corner_reg[i] <= corner_in[i];
        end
    end
    assign corner_out = corner_reg;
    assign mid_out = mid_reg;

    // midpoint sum magnitudes
    logic [MAG_BITS-1:0] mag_c [3];
    logic [2:0] neg_c;
    always_comb
    begin
        logic signed [COORD_BITS:0] s;
        logic [COORD_BITS:0] m;
        for (int i = 0; i < 3; i++)
        begin
            case (cmd.mid_sel)
                2'd0: s = {corner_reg[i][COORD_BITS-1], corner_reg[i]}
                        + {corner_reg[3+i][COORD_BITS-1], corner_reg[3+i]};
                2'd1: s = {corner_reg[3+i][COORD_BITS-1], corner_reg[3+i]}
                        + {corner_reg[6+i][COORD_BITS-1], corner_reg[6+i]};
                default: s = {corner_reg[6+i][COORD_BITS-1], corner_reg[6+i]}
                        + {corner_reg[i][COORD_BITS-1], corner_reg[i]};
            endcase
            neg_c[i] = s[COORD_BITS];
            m = s[COORD_BITS] ? (~s + 1'b1) : s;
            mag_c[i] = MAG_BITS'(m >> SUM_SHIFT);
        end
    end

    // square root: one result bit per cycle, with the sum of the three squares
    // accumulated first
    logic [RAD_BITS-1:0] rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [RAD_BITS-1:0] rad_reg;
    logic [SQ_ITER_BITS-1:0] sq_cnt_reg;
    logic [1:0] acc_cnt_reg;
    logic [SQ_BITS-1:0] sum_reg;
    logic sq_busy_reg, acc_busy_reg, sq_done_reg, zero_reg;

    logic [2*MAG_BITS-1:0] sqr;
    assign sqr = mag_reg[acc_cnt_reg] * mag_reg[acc_cnt_reg];

    logic [RAD_BITS-1:0] trial;
    logic [RAD_BITS-1:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg[RAD_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
        trial = RAD_BITS'({root_reg, 2'b01});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_busy_reg <= 1'b0;
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            acc_cnt_reg <= '0;
            sq_cnt_reg <= '0;
        end
        else
        begin
            sq_done_reg <= 1'b0;
            if (cmd.mid_start)
            begin
                mag_reg <= mag_c;
                neg_reg <= neg_c;
                sel_reg <= cmd.mid_sel;
                acc_busy_reg <= 1'b1;
                acc_cnt_reg <= '0;
                sum_reg <= '0;
            end
            else if (acc_busy_reg)
            begin
                sum_reg <= sum_reg + SQ_BITS'(sqr);
                if (acc_cnt_reg == 2'd2)
                begin
                    acc_busy_reg <= 1'b0;
                    sq_busy_reg <= 1'b1;
                    sq_cnt_reg <= '0;
                    rad_reg <= {sum_reg + SQ_BITS'(sqr), 24'd0};
                    rem_reg <= '0;
                    root_reg <= '0;
                    zero_reg <= (sum_reg + SQ_BITS'(sqr)) == '0;
                end
                acc_cnt_reg <= acc_cnt_reg + 2'd1;
            end
            else if (sq_busy_reg)
            begin
                rad_reg <= {rad_reg[RAD_BITS-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
                end
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == SQ_ITER_BITS'(ROOT_BITS - 1))
                begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [NUM_BITS-1:0] num_reg;
    logic [ROOT_BITS:0] drem_reg;
    logic [QBITS-1:0] quo_reg;
    logic [DIV_ITER_BITS-1:0] div_cnt_reg;
    logic [1:0] axis_reg;
    logic div_busy_reg, div_done_reg, mul_reg;
    logic [MAG_BITS+sts_pkg::RADIUS_BITS-1:0] prod_reg;

    // midpoint coordinate slot: 3 * midpoint + axis
    logic [3:0] mid_idx;
    assign mid_idx = {1'b0, sel_reg, 1'b0} + {2'b00, sel_reg} + {2'b00, axis_reg};

    logic [ROOT_BITS:0] dsh;
    assign dsh = {drem_reg[ROOT_BITS-1:0], num_reg[NUM_BITS-1]};

    logic signed [QBITS+1:0] sq_val;
    logic signed [QBITS+1:0] hi_lim, lo_lim;
    assign hi_lim = (QBITS+2)'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    assign lo_lim = -hi_lim - 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            mul_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            mul_reg <= 1'b0;
            if (cmd.div_start)
            begin
                prod_reg <= mag_reg[cmd.axis] * radius;
                axis_reg <= cmd.axis;
                mul_reg <= 1'b1;
            end
            else if (mul_reg)
            begin
                num_reg <= NUM_BITS'({prod_reg, 12'd0}) + NUM_BITS'(root_reg >> 1);
                drem_reg <= '0;
                quo_reg <= '0;
                div_cnt_reg <= '0;
                div_busy_reg <= !zero_reg;
                if (zero_reg)
                begin
                    mid_reg[mid_idx] <= '0;
                    div_done_reg <= 1'b1;
                end
            end
            else if (div_busy_reg)
            begin
                num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
                if (dsh >= {1'b0, root_reg})
                begin
                    drem_reg <= dsh - {1'b0, root_reg};
                    quo_reg <= {quo_reg[QBITS-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dsh;
                    quo_reg <= {quo_reg[QBITS-2:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_ITER_BITS'(QBITS - 1))
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                    mid_reg[mid_idx] <= COORD_BITS'(
                        (sq_val > hi_lim) ? hi_lim : (sq_val < lo_lim) ? lo_lim : sq_val);
                end
            end
        end
    end

    // final quotient bit folded in for saturation and sign
    always_comb
    begin
        logic [QBITS-1:0] q;
        q = (dsh >= {1'b0, root_reg}) ? {quo_reg[QBITS-2:0], 1'b1}
                                      : {quo_reg[QBITS-2:0], 1'b0};
        sq_val = neg_reg[axis_reg] ? -$signed({2'b00, q}) : $signed({2'b00, q});
    end

    assign stat.sqrt_done = sq_done_reg;
    assign stat.div_done = div_done_reg;
    assign stat.zero_len = zero_reg;
endmodule

// ===== rtl/sts_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_controller
// Sequences three midpoints, three axis divisions each, and four results.
// ----------------------------------------------------------------------------
module sts_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_take,
    input  sts_pkg::dp_stat_t stat,
    input  logic              out_free,
    output sts_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              emit,
    output logic [1:0]        sub_idx
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MID  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] mid_reg, mid_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] sub_reg, sub_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mid_reg <= '0;
            axis_reg <= '0;
            sub_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mid_reg <= mid_next;
            axis_reg <= axis_next;
            sub_reg <= sub_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mid_next = mid_reg;
        axis_next = axis_reg;
        sub_next = sub_reg;
        cmd = '0;
        cmd.mid_sel = mid_reg;
        cmd.axis = axis_reg;
        emit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cmd.load = 1'b1;
                    mid_next = '0;
                    state_next = ST_MID;
                end
            end
            ST_MID:
            begin
                cmd.mid_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    axis_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (axis_reg != 2'd2)
                    begin
                        axis_next = axis_reg + 2'd1;
                        state_next = ST_DIV;
                    end
                    else if (mid_reg != 2'd2)
                    begin
                        mid_next = mid_reg + 2'd1;
                        state_next = ST_MID;
                    end
                    else
                    begin
                        sub_next = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg == 2'd3)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign sub_idx = sub_reg;
endmodule

// ===== rtl/sphere_triangle_subdivider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider
// Splits one sphere triangle into four, with normalized edge midpoints.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | new_pass, corner_{a,b,c}_{x,y,z}
//  out     | out_valid / out_stall | vert{0,1,2}_{x,y,z}, index, flags
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The bit-serial square root and divider set the time from one accepted
// transaction to the next; it is shorter on a zero-length sum, which
// skips the division of each axis.
// Reset clears control state, the triangle count, the pass flag and the
// base and sets the radius to 16384; data and result registers are not reset.
// Input is stalled while a triangle is in work; an output register
// holds each result until taken, and output stalls add to the time per triangle.
module sphere_triangle_subdivider #(
    parameter int COORD_BITS = 18,
    parameter int INDEX_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic new_pass,
    input  logic signed [COORD_BITS-1:0] corner_a_x,
    input  logic signed [COORD_BITS-1:0] corner_a_y,
    input  logic signed [COORD_BITS-1:0] corner_a_z,
    input  logic signed [COORD_BITS-1:0] corner_b_x,
    input  logic signed [COORD_BITS-1:0] corner_b_y,
    input  logic signed [COORD_BITS-1:0] corner_b_z,
    input  logic signed [COORD_BITS-1:0] corner_c_x,
    input  logic signed [COORD_BITS-1:0] corner_c_y,
    input  logic signed [COORD_BITS-1:0] corner_c_z,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [COORD_BITS-1:0] vert0_x,
    output logic signed [COORD_BITS-1:0] vert0_y,
    output logic signed [COORD_BITS-1:0] vert0_z,
    output logic signed [COORD_BITS-1:0] vert1_x,
    output logic signed [COORD_BITS-1:0] vert1_y,
    output logic signed [COORD_BITS-1:0] vert1_z,
    output logic signed [COORD_BITS-1:0] vert2_x,
    output logic signed [COORD_BITS-1:0] vert2_y,
    output logic signed [COORD_BITS-1:0] vert2_z,
    output logic [INDEX_BITS-1:0] first_vertex_index,
    output logic index_overflow,
    output logic last_of_four,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int CB = sts_pkg::COUNT_BITS;
    localparam int IDX_W = (INDEX_BITS > sts_pkg::BASE_BITS ? INDEX_BITS
                           : sts_pkg::BASE_BITS) + CB + 6;

    logic [sts_pkg::RADIUS_BITS-1:0] radius_reg;
    logic [sts_pkg::BASE_BITS-1:0] base_reg;
    logic [CB-1:0] count_reg;
    logic pass_reg;

    sts_pkg::dp_cmd_t cmd;
    sts_pkg::dp_stat_t stat;
    logic busy, emit;
    logic [1:0] sub_idx;
    logic signed [COORD_BITS-1:0] cin [9];
    logic signed [COORD_BITS-1:0] cor [9];
    logic signed [COORD_BITS-1:0] mid [9];

    assign cin = '{corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                   corner_b_z, corner_c_x, corner_c_y, corner_c_z};

    logic in_take;
    assign in_stall = busy;
    assign in_take = in_valid && !busy;
    assign cfg_ready = 1'b1;

    sts_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_take(in_take), .stat(stat),
        .out_free(!out_valid || !out_stall), .cmd(cmd), .busy(busy),
        .emit(emit), .sub_idx(sub_idx)
    );

    sts_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .radius(radius_reg),
        .corner_in(cin), .corner_out(cor), .mid_out(mid)
    );

    // config and triangle count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd16384;
            base_reg <= '0;
            count_reg <= '0;
            pass_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sts_pkg::CFG_RADIUS: radius_reg <= cfg_data[15:0];
                    sts_pkg::CFG_BASE: base_reg <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (in_take)
                pass_reg <= new_pass;
            if (emit && sub_idx == 2'd3)
            begin
                if (pass_reg)
                    count_reg <= CB'(1);
                else if (count_reg != {CB{1'b1}})
                    count_reg <= count_reg + 1'b1;
            end
        end
    end

    // vertex select and index
    logic [CB-1:0] cur_cnt;
    logic [IDX_W-1:0] idx;
    logic signed [COORD_BITS-1:0] v [9];
    assign cur_cnt = pass_reg ? '0 : count_reg;
    assign idx = IDX_W'(base_reg) + IDX_W'(cur_cnt) * IDX_W'(12)
               + IDX_W'(sub_idx) * IDX_W'(3);
    always_comb
    begin
        case (sub_idx)
            2'd0: v = '{cor[0], cor[1], cor[2], mid[0], mid[1], mid[2],
                        mid[6], mid[7], mid[8]};
            2'd1: v = '{mid[0], mid[1], mid[2], cor[3], cor[4], cor[5],
                        mid[3], mid[4], mid[5]};
            2'd2: v = '{mid[3], mid[4], mid[5], cor[6], cor[7], cor[8],
                        mid[6], mid[7], mid[8]};
            default: v = '{mid[0], mid[1], mid[2], mid[3], mid[4], mid[5],
                           mid[6], mid[7], mid[8]};
        endcase
    end

    // output register
    logic ovf;
    assign ovf = idx > IDX_W'({INDEX_BITS{1'b1}});
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (emit)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            {vert0_x, vert0_y, vert0_z} <= {v[0], v[1], v[2]};
            {vert1_x, vert1_y, vert1_z} <= {v[3], v[4], v[5]};
            {vert2_x, vert2_y, vert2_z} <= {v[6], v[7], v[8]};
            first_vertex_index <= ovf ? {INDEX_BITS{1'b1}} : INDEX_BITS'(idx);
            index_overflow <= ovf;
            last_of_four <= (sub_idx == 2'd3);
        end
    end

    // assertions
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_take) else $error("input taken while busy");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid || !out_stall)) else $error("result overwritten");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(first_vertex_index))
        else $error("stalled result changed");
endmodule
